FILE: hw/rtl/dswe_pkg.sv
// Shared widths, constants and types for the dual-sensor worst-error PI drive.
package dswe_pkg;

	localparam int SENSOR_WIDTH   = 16;
	localparam int GAIN_WIDTH     = 16;
	localparam int GAIN_FRAC_BITS = 8;
	localparam int ERR_WIDTH      = SENSOR_WIDTH + 1;
	localparam int DERR_WIDTH     = ERR_WIDTH + 1;
	localparam int PKP_WIDTH      = GAIN_WIDTH + DERR_WIDTH;
	localparam int PKI_WIDTH      = GAIN_WIDTH + ERR_WIDTH;
	localparam int UPD_WIDTH      = PKP_WIDTH + 1;
	localparam int SUM_WIDTH      = UPD_WIDTH + 1;
	// sign, 9 integer bits for the clamp trip point, then the fraction
	localparam int ACC_WIDTH      = GAIN_FRAC_BITS + 10;
	localparam int DRIVE_WIDTH    = 9;
	localparam int CFG_IDX_WIDTH  = 2;

	// stream widths, padded to whole bytes
	localparam int S_TDATA_WIDTH  = ((3 * SENSOR_WIDTH + 7) / 8) * 8;
	localparam int M_TDATA_WIDTH  = ((DRIVE_WIDTH + 7) / 8) * 8;

	localparam int CLAMP_TRIP = 255;
	localparam int CLAMP_HOLD = 254;
	localparam int KICK_ERROR = 10;

	localparam int ACC_TRIP = CLAMP_TRIP * (1 << GAIN_FRAC_BITS);
	localparam int ACC_HOLD = CLAMP_HOLD * (1 << GAIN_FRAC_BITS);

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_KP_GAIN = 2'd0,
		REG_KI_GAIN = 2'd1
	} cfg_reg_t;

	// Selected error of one beat, as handed to the multiply stage.
	typedef struct packed {
		logic signed [ERR_WIDTH-1:0]  err;
		logic signed [DERR_WIDTH-1:0] derr;
		logic                         restart;
	} err_t;

endpackage

FILE: hw/rtl/dual_sensor_worst_error_pi_drive_unit.sv
// Top level of the dual-sensor worst-error incremental PI drive.
//
// Input stream (s_*): one beat carries encoder_a, encoder_b and target.
// Output stream (m_*): one beat per input beat carrying the signed drive.
// Configuration: cfg_we/cfg_idx/cfg_wdata write kp_gain (0) and ki_gain (1),
// both signed Q8.8; other indexes are ignored. Write only while idle.
//
// Three stages: error selection into _s1, gain products into _s2, then the
// accumulator add and clamp into the output register. m_tvalid rises once
// the beat has passed _s1 and _s2; throughput is one beat per cycle while m_tready is high.
// The only loop is accumulator add plus clamp in the last stage; the error
// and direction state is updated when the input beat is taken.
//
// Reset clears gains, accumulator, previous error and direction, and empties
// the pipeline. When the receiver stalls, each stage holds once the next one
// is full; s_tready drops only with all three stages occupied, so a beat is
// still taken while a finished result waits.
module dual_sensor_worst_error_pi_drive_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [dswe_pkg::CFG_IDX_WIDTH-1:0]    cfg_idx,
	input  logic [dswe_pkg::GAIN_WIDTH-1:0]       cfg_wdata,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [dswe_pkg::S_TDATA_WIDTH-1:0]    s_tdata, // encoder_a, encoder_b, target
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [dswe_pkg::M_TDATA_WIDTH-1:0]    m_tdata  // drive, zero pad
);
	import dswe_pkg::*;

	logic signed [GAIN_WIDTH-1:0] kp_q, ki_q;

	logic                         v_s1, v_s2, out_v_q;
	logic                         en1, en2, en3, s_acc;
	err_t                         sel, sel_s1;
	logic                         restart_s2;
	logic signed [UPD_WIDTH-1:0]  upd_s2;
	logic signed [PKP_WIDTH-1:0]  p_kp;
	logic signed [PKI_WIDTH-1:0]  p_ki;
	logic signed [ACC_WIDTH-1:0]  acc_q, acc_base, acc_nxt;
	logic signed [SUM_WIDTH-1:0]  sum;
	logic        [ACC_WIDTH-1:0]  mag;
	logic        [DRIVE_WIDTH-1:0] dmag, drive_nxt, drive_q;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= '0;
			ki_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_KP_GAIN: kp_q <= cfg_wdata;
				REG_KI_GAIN: ki_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// pipeline flow: a stage loads when it is empty or its content moves on
	assign en3      = !out_v_q || m_tready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;
	assign s_acc    = s_tvalid && s_tready;

	dswe_err_sel u_err_sel (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (s_acc),
		.encoder_a (s_tdata[0 +: SENSOR_WIDTH]),
		.encoder_b (s_tdata[SENSOR_WIDTH +: SENSOR_WIDTH]),
		.target    (s_tdata[2*SENSOR_WIDTH +: SENSOR_WIDTH]),
		.sel       (sel)
	);

	always_comb begin
		p_kp = kp_q * sel_s1.derr;
		p_ki = ki_q * sel_s1.err;
	end

	always_comb begin
		acc_base = restart_s2 ? '0 : acc_q;
		sum      = SUM_WIDTH'(acc_base) + SUM_WIDTH'(upd_s2);
		priority if (sum >= SUM_WIDTH'(ACC_TRIP)) begin
			acc_nxt = ACC_WIDTH'(ACC_HOLD);
		end else if (sum <= -SUM_WIDTH'(ACC_TRIP)) begin
			acc_nxt = -ACC_WIDTH'(ACC_HOLD);
		end else begin
			acc_nxt = ACC_WIDTH'(sum);
		end
		// truncate toward zero
		mag       = acc_nxt[ACC_WIDTH-1] ? ACC_WIDTH'(-acc_nxt) : ACC_WIDTH'(acc_nxt);
		dmag      = mag[GAIN_FRAC_BITS +: DRIVE_WIDTH];
		drive_nxt = acc_nxt[ACC_WIDTH-1] ? DRIVE_WIDTH'(-dmag) : dmag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
			acc_q   <= '0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) out_v_q <= v_s2;
			if (en3 && v_s2) acc_q <= acc_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) sel_s1 <= sel;
		if (en2 && v_s1) begin
			restart_s2 <= sel_s1.restart;
			upd_s2     <= UPD_WIDTH'(p_kp) + UPD_WIDTH'(p_ki);
		end
		if (en3 && v_s2) drive_q <= drive_nxt;
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {{(M_TDATA_WIDTH-DRIVE_WIDTH){1'b0}}, drive_q};

	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_q <= ACC_WIDTH'(ACC_HOLD) + ACC_WIDTH'((1 << GAIN_FRAC_BITS) - 1)) &&
		(acc_q >= -ACC_WIDTH'(ACC_HOLD) - ACC_WIDTH'((1 << GAIN_FRAC_BITS) - 1)))
		else $error("accumulator outside clamp range");

	a_acc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(acc_q))
		else $error("accumulator moved while output stalled");

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && v_s2 && m_tvalid))
		else $error("input blocked with a pipeline bubble");

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(drive_q) <= $signed(DRIVE_WIDTH'(CLAMP_HOLD)) &&
			$signed(drive_q) >= -$signed(DRIVE_WIDTH'(CLAMP_HOLD))))
		else $error("drive outside limits");

endmodule

FILE: hw/rtl/dswe_err_sel.sv
// Worst-error selection and direction tracking, one beat per cycle while accept is high.
module dswe_err_sel (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  logic signed [dswe_pkg::SENSOR_WIDTH-1:0] encoder_a,
	input  logic signed [dswe_pkg::SENSOR_WIDTH-1:0] encoder_b,
	input  logic signed [dswe_pkg::SENSOR_WIDTH-1:0] target,
	output dswe_pkg::err_t                        sel
);
	import dswe_pkg::*;

	logic                        dir_q;
	logic signed [ERR_WIDTH-1:0] prev_err_q;

	logic                        dir;
	logic signed [ERR_WIDTH-1:0] ea, eb, e;
	logic        [ERR_WIDTH-1:0] abs_a, abs_b;
	logic signed [ERR_WIDTH-1:0] prev_eff;

	always_comb begin
		dir   = (target > 0);
		ea    = ERR_WIDTH'(encoder_a) - ERR_WIDTH'(target);
		eb    = ERR_WIDTH'(encoder_b) - ERR_WIDTH'(target);
		abs_a = ea[ERR_WIDTH-1] ? ERR_WIDTH'(-ea) : ERR_WIDTH'(ea);
		abs_b = eb[ERR_WIDTH-1] ? ERR_WIDTH'(-eb) : ERR_WIDTH'(eb);
		sel.restart = (dir != dir_q);
		// direction change: restart from a fixed kick
		priority if (sel.restart) begin
			e = dir ? ERR_WIDTH'(KICK_ERROR) : -ERR_WIDTH'(KICK_ERROR);
		end else if (abs_a >= abs_b) begin
			e = ea;
		end else begin
			e = eb;
		end
		prev_eff = sel.restart ? '0 : prev_err_q;
		sel.err  = e;
		sel.derr = DERR_WIDTH'(e) - DERR_WIDTH'(prev_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q      <= 1'b0;
			prev_err_q <= '0;
		end else if (accept) begin
			dir_q      <= dir;
			prev_err_q <= e;
		end
	end

endmodule
